[rtl/core/u2u8_pkg.sv]
// shared types and constants for the utf-16 to utf-8 encoder
// no dependencies
package u2u8_pkg;

	localparam int QDEPTH = 4;
	localparam int MAX_BYTES = 6;
	localparam int CNT_W = $clog2(MAX_BYTES + 1);
	localparam int IDX_W = $clog2(MAX_BYTES);

	localparam logic [15:0] MASK_ONE_BYTE = 16'hFF80;
	localparam logic [15:0] MASK_TWO_BYTE = 16'hF800;
	localparam logic [15:0] MASK_SURR     = 16'hFC00;
	localparam logic [15:0] HIGH_SURR     = 16'hD800;
	localparam logic [15:0] LOW_SURR      = 16'hDC00;
	localparam logic [7:0]  LEAD_TWO      = 8'hC0;
	localparam logic [7:0]  LEAD_THREE    = 8'hE0;
	localparam logic [7:0]  LEAD_FOUR     = 8'hF0;
	localparam logic [7:0]  CONT_MARK     = 8'h80;
	localparam logic [7:0]  CONT_BITS     = 8'h3F;

	// all bytes caused by one code unit, slot 0 goes out first
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [CNT_W-1:0]          count;
	} burst_t;

endpackage

[rtl/core/u2u8_front.sv]
// front end: accepts code units, tracks the held high surrogate, builds byte bursts
// depends on u2u8_pkg
module u2u8_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic [15:0]            code_unit,
	output logic                   push,
	output u2u8_pkg::burst_t       burst
);

	logic        held_q;
	logic [9:0]  held_bits_q;
	logic        is_low;
	logic        is_high;
	logic        pair;
	logic [10:0] plane_hi;
	logic [20:0] cp;
	logic [2:0][7:0] ub;
	logic [1:0]  uc;
	logic [2:0][7:0] pre;
	logic [15:0] hs;

	assign is_low   = (code_unit & u2u8_pkg::MASK_SURR) == u2u8_pkg::LOW_SURR;
	assign is_high  = (code_unit & u2u8_pkg::MASK_SURR) == u2u8_pkg::HIGH_SURR;
	assign pair     = held_q && is_low;
	// code point = 0x10000 + (high << 10) + low
	assign plane_hi = {1'b0, held_bits_q} + 11'd64;
	assign cp       = {plane_hi, code_unit[9:0]};
	assign hs       = u2u8_pkg::HIGH_SURR | {6'd0, held_bits_q};

	assign pre[0] = u2u8_pkg::LEAD_THREE | {4'd0, hs[15:12]};
	assign pre[1] = u2u8_pkg::CONT_MARK | {2'd0, hs[11:6]};
	assign pre[2] = u2u8_pkg::CONT_MARK | {2'd0, hs[5:0]};

	// bytes for the unit on its own
	always_comb begin
		ub = '0;
		uc = 2'd0;
		if (code_unit == 16'd0) begin
			uc = 2'd1;
		end else if ((code_unit & u2u8_pkg::MASK_ONE_BYTE) == 16'd0) begin
			ub[0] = code_unit[7:0];
			uc    = 2'd1;
		end else if ((code_unit & u2u8_pkg::MASK_TWO_BYTE) == 16'd0) begin
			ub[0] = u2u8_pkg::LEAD_TWO | {3'd0, code_unit[10:6]};
			ub[1] = u2u8_pkg::CONT_MARK | {2'd0, code_unit[5:0]};
			uc    = 2'd2;
		end else if (!is_high) begin
			ub[0] = u2u8_pkg::LEAD_THREE | {4'd0, code_unit[15:12]};
			ub[1] = u2u8_pkg::CONT_MARK | {2'd0, code_unit[11:6]};
			ub[2] = u2u8_pkg::CONT_MARK | {2'd0, code_unit[5:0]};
			uc    = 2'd3;
		end
	end

	always_comb begin
		burst = '0;
		if (pair) begin
			burst.bytes[0] = u2u8_pkg::LEAD_FOUR | {5'd0, cp[20:18]};
			burst.bytes[1] = u2u8_pkg::CONT_MARK | {2'd0, cp[17:12]};
			burst.bytes[2] = u2u8_pkg::CONT_MARK | {2'd0, cp[11:6]};
			burst.bytes[3] = u2u8_pkg::CONT_MARK | {2'd0, cp[5:0]};
			burst.count    = u2u8_pkg::CNT_W'(4);
		end else if (held_q) begin
			burst.bytes[0] = pre[0];
			burst.bytes[1] = pre[1];
			burst.bytes[2] = pre[2];
			burst.bytes[3] = ub[0];
			burst.bytes[4] = ub[1];
			burst.bytes[5] = ub[2];
			burst.count    = u2u8_pkg::CNT_W'(3) + u2u8_pkg::CNT_W'(uc);
		end else begin
			burst.bytes[0] = ub[0];
			burst.bytes[1] = ub[1];
			burst.bytes[2] = ub[2];
			burst.count    = u2u8_pkg::CNT_W'(uc);
		end
	end

	assign push = accept && (burst.count != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= 1'b0;
			held_bits_q <= '0;
		end else if (accept) begin
			held_q      <= is_high;
			held_bits_q <= is_high ? code_unit[9:0] : 10'd0;
		end
	end

endmodule

[rtl/core/u2u8_queue.sv]
// short burst queue between the front end and the byte serializer
// depends on u2u8_pkg
module u2u8_queue #(
	parameter int DEPTH = u2u8_pkg::QDEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  u2u8_pkg::burst_t wr_burst,
	input  logic             pop,
	output logic             head_valid,
	output u2u8_pkg::burst_t head,
	output logic             full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W = $clog2(DEPTH + 1);

	u2u8_pkg::burst_t mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic              do_pop;

	assign head_valid = fill_q != '0;
	assign full       = fill_q == FILL_W'(DEPTH);
	assign head       = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_burst;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

[rtl/core/u2u8_back.sv]
// back end: head burst to output register, one byte per cycle unless stalled
// depends on u2u8_pkg
module u2u8_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  u2u8_pkg::burst_t head,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       out_byte,
	output logic             last_of_run
);

	logic [u2u8_pkg::IDX_W-1:0] idx_q;
	logic                       load;
	logic                       final_byte;

	assign load       = head_valid && (!out_valid || !out_stall);
	assign final_byte = u2u8_pkg::CNT_W'(idx_q) == (head.count - 1'b1);
	assign pop        = load && final_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (load) begin
				out_valid <= 1'b1;
				idx_q     <= final_byte ? '0 : idx_q + 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte    <= head.bytes[idx_q];
			last_of_run <= final_byte;
		end
	end

endmodule

[rtl/core/utf16_to_utf8_encoder_core.sv]
// utf-16 to utf-8 encoder: one code unit per input beat, one utf-8 byte per output beat
// path: an accepted unit's burst is written into the queue, then its first byte passes through the output register
// throughput: one input beat per cycle while the burst queue has room; output one byte
//   per cycle while out_stall is low, so a unit keeps the byte serializer busy until all of its
//   bytes are out (0 to 6, typically 1 to 3); the serializer sets the sustained rate
// reset: arst_n clears the held surrogate, the queue pointers and the output valid
module utf16_to_utf8_encoder_core #(
	parameter int QDEPTH = u2u8_pkg::QDEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] code_unit,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        last_of_run
);

	logic             accept;
	logic             push;
	u2u8_pkg::burst_t burst;
	logic             full;
	logic             head_valid;
	u2u8_pkg::burst_t head;
	logic             pop;

	// input stalls only on a full queue, so a unit that makes no byte still waits for room
	assign in_stall = full;
	assign accept   = in_valid && !in_stall;

	// front end classifies the unit and pairs surrogates into whole bursts
	u2u8_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.code_unit (code_unit),
		.push      (push),
		.burst     (burst)
	);

	// decouples the unit rate from the byte rate
	u2u8_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_burst   (burst),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head),
		.full       (full)
	);

	// serializer with the output register, last byte of a burst flags last_of_run
	u2u8_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);

endmodule

[rtl/core/u2u8_checker.sv]
// port-level checks for the utf-16 to utf-8 encoder core
// depends on utf16_to_utf8_encoder_core ports only, attached by bind
module u2u8_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [15:0] code_unit,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  out_byte,
	input logic        last_of_run
);

	logic prev_last_q;

	// tracks whether the next output beat opens a new run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_last_q <= 1'b1;
		end else if (out_valid && !out_stall) begin
			prev_last_q <= last_of_run;
		end
	end

	// stalled input beat holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(code_unit))
		else $error("input beat changed while stalled");

	// stalled beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last_of_run))
		else $error("output beat changed while stalled");

	// the terminator byte always ends its run
	a_zero_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_byte == 8'h00 |-> last_of_run)
		else $error("zero byte without last_of_run");

	// a run never opens with a continuation byte
	a_run_lead: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && prev_last_q |-> out_byte[7:6] != 2'b10)
		else $error("run starts with continuation byte");

	// no overlong two-byte leads and nothing above four-byte leads
	a_legal_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_byte[7:3] != 5'b11111 && out_byte[7:1] != 7'b1100000)
		else $error("illegal utf-8 byte");

endmodule

bind utf16_to_utf8_encoder_core u2u8_checker u_u2u8_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.code_unit   (code_unit),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.out_byte    (out_byte),
	.last_of_run (last_of_run)
);

[test/utf8_stream_monitor.sv]
// watches both channels of the utf-16 to utf-8 encoder and checks every output byte
// keeps its own model of the held surrogate, depends on u2u8_pkg
module utf8_stream_monitor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [15:0] code_unit,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [7:0]  out_byte,
	input  logic        last_of_run,
	output int          pending_bytes,
	output int          mismatches
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} utf8_beat_t;

	utf8_beat_t expected_bytes[$];
	utf8_beat_t want;
	logic       held_valid;
	logic [9:0] held_bits;
	int         error_count = 0;

	assign mismatches = error_count;

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		error_count++;
	endtask

	task automatic push_byte(input logic [7:0] b);
		expected_bytes.push_back('{value: b, last: 1'b0});
	endtask

	task automatic push_three_byte(input logic [15:0] u);
		push_byte(u2u8_pkg::LEAD_THREE | {4'd0, u[15:12]});
		push_byte(u2u8_pkg::CONT_MARK | {2'd0, u[11:6]});
		push_byte(u2u8_pkg::CONT_MARK | {2'd0, u[5:0]});
	endtask

	// bytes that one code unit should produce, appended to the queue
	task automatic predict_utf8(input logic [15:0] u);
		int         start_size;
		logic [20:0] cp;
		utf8_beat_t tail;
		logic       paired;
		start_size = expected_bytes.size();
		paired = 1'b0;
		if (held_valid) begin
			held_valid = 1'b0;
			if ((u & u2u8_pkg::MASK_SURR) == u2u8_pkg::LOW_SURR) begin
				// surrogate pair, four-byte sequence
				cp = 21'h10000 + {1'b0, held_bits, u[9:0]};
				push_byte(u2u8_pkg::LEAD_FOUR | {5'd0, cp[20:18]});
				push_byte(u2u8_pkg::CONT_MARK | {2'd0, cp[17:12]});
				push_byte(u2u8_pkg::CONT_MARK | {2'd0, cp[11:6]});
				push_byte(u2u8_pkg::CONT_MARK | {2'd0, cp[5:0]});
				paired = 1'b1;
			end else begin
				// orphaned high surrogate goes out as three bytes
				push_three_byte(u2u8_pkg::HIGH_SURR | {6'd0, held_bits});
			end
			held_bits = '0;
		end
		if (!paired) begin
			if (u == 16'h0000)
				push_byte(8'h00);
			else if ((u & u2u8_pkg::MASK_ONE_BYTE) == 16'h0000)
				push_byte(u[7:0]);
			else if ((u & u2u8_pkg::MASK_TWO_BYTE) == 16'h0000) begin
				push_byte(u2u8_pkg::LEAD_TWO | {3'd0, u[10:6]});
				push_byte(u2u8_pkg::CONT_MARK | {2'd0, u[5:0]});
			end else if ((u & u2u8_pkg::MASK_SURR) == u2u8_pkg::HIGH_SURR) begin
				held_valid = 1'b1;
				held_bits = u[9:0];
			end else
				push_three_byte(u);
		end
		if (expected_bytes.size() > start_size) begin
			tail = expected_bytes.pop_back();
			tail.last = 1'b1;
			expected_bytes.push_back(tail);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid = 1'b0;
			held_bits = '0;
			expected_bytes.delete();
			pending_bytes <= 0;
		end else begin
			if (in_valid && !in_stall)
				predict_utf8(code_unit);
			if (out_valid && !out_stall) begin
				if (expected_bytes.size() == 0)
					report_mismatch($sformatf("unexpected byte %02h last %b",
						out_byte, last_of_run));
				else begin
					want = expected_bytes.pop_front();
					if (out_byte !== want.value)
						report_mismatch($sformatf("out_byte %02h, expected %02h",
							out_byte, want.value));
					if (last_of_run !== want.last)
						report_mismatch($sformatf("last_of_run %b on byte %02h, expected %b",
							last_of_run, want.value, want.last));
				end
			end
			pending_bytes <= expected_bytes.size();
		end
	end

endmodule

[test/utf16_to_utf8_encoder_core_tb.sv]
// top of the utf-16 to utf-8 encoder testbench: clock, reset, code unit stimulus, verdict
// depends on u2u8_pkg, utf8_stream_monitor and the encoder core
module utf16_to_utf8_encoder_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// generous bound: ~100 units, up to six bytes each, every byte behind a longest stall burst
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_UNITS = 74;
	// the random units from here on run without idling on either side
	localparam int QUIET_FROM = 56;
	localparam int SETTLE_CYCLES = 20;

	// extremes of every range, pairs at both ends of the supplementary planes,
	// and a held high surrogate followed by each kind of unit
	localparam int N_DIRECTED = 26;
	localparam logic [15:0] DIRECTED_UNITS [N_DIRECTED] = '{
		16'h0001, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hD7FF, 16'hE000,
		16'hFFFF,                                   // all bits set
		16'hDC00, 16'hDFFF,                         // lone low surrogates
		16'hD800, 16'hDC00,                         // lowest pair, u+10000
		16'hDBFF, 16'hDFFF,                         // highest pair, u+10ffff
		16'hD834, 16'h0041,                         // held, then ascii
		16'hD800, 16'hDBFF, 16'hDC01,               // held, then another high
		16'hDABC, 16'h0000,                         // held, then terminator
		16'hD900, 16'h0123,                         // held, then two-byte unit
		16'hDB00, 16'hFFFF,                         // held, then three-byte unit
		16'h0000                                    // plain terminator
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [15:0] code_unit;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  out_byte;
	logic        last_of_run;
	int          pending_bytes;
	int          mismatches;
	logic        quiet;

	utf16_to_utf8_encoder_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.code_unit   (code_unit),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);

	utf8_stream_monitor i_monitor (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.code_unit     (code_unit),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.last_of_run   (last_of_run),
		.pending_bytes (pending_bytes),
		.mismatches    (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: any hang ends the run as a failure
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("utf16_to_utf8_encoder_core test failed");
		$finish;
	end

	// receiver back-pressure: free stretches, some long, broken by stall bursts
	initial begin : stall_gen
		int n;
		out_stall <= 1'b0;
		forever begin
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
			repeat (n) @(posedge clk);
			if (!quiet) begin
				out_stall <= 1'b1;
				n = $urandom_range(1, 13);
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// one input beat; called at a rising edge, returns at the edge that accepts it
	task automatic send_unit(input logic [15:0] u);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 13);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		code_unit <= u;
		do @(posedge clk); while (in_stall);
	endtask

	// hold off the sender until every predicted byte has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_bytes != 0) @(posedge clk);
	endtask

	function automatic logic [15:0] bmp_three_byte();
		if ($urandom_range(0, 1) == 0)
			return 16'($urandom_range(16'h0800, 16'hD7FF));
		return 16'($urandom_range(16'hE000, 16'hFFFF));
	endfunction

	initial begin : stimulus
		int sent;
		int kind;
		quiet = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		code_unit <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_UNITS[i])
			send_unit(DIRECTED_UNITS[i]);
		wait_drained();

		// mostly well-formed text with random content, some noise and broken pairs
		sent = 0;
		while (sent < RANDOM_UNITS) begin
			if (sent >= QUIET_FROM)
				quiet = 1'b1;
			kind = $urandom_range(0, 9);
			case (kind)
				0, 1, 2: begin
					send_unit(16'($urandom_range(1, 16'h007F)));
					sent += 1;
				end
				3: begin
					send_unit(16'($urandom_range(16'h0080, 16'h07FF)));
					sent += 1;
				end
				4: begin
					send_unit(bmp_three_byte());
					sent += 1;
				end
				5, 6: begin
					send_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
					send_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));
					sent += 2;
				end
				7: begin
					// high surrogate followed by anything at all
					send_unit(16'($urandom_range(16'hD800, 16'hDBFF)));
					send_unit(16'($urandom_range(0, 16'hFFFF)));
					sent += 2;
				end
				8: begin
					send_unit(16'($urandom_range(16'hDC00, 16'hDFFF)));
					sent += 1;
				end
				default: begin
					if ($urandom_range(0, 1) == 0)
						send_unit(16'h0000);
					else
						send_unit(16'($urandom_range(0, 16'hFFFF)));
					sent += 1;
				end
			endcase
			if (sent == RANDOM_UNITS / 2)
				wait_drained();
		end

		// flush whatever surrogate may still be held, then drain
		send_unit(16'h0000);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("utf16_to_utf8_encoder_core test passed");
		else
			$display("utf16_to_utf8_encoder_core test failed");
		$finish;
	end

endmodule

[files.f]
rtl/core/u2u8_pkg.sv
rtl/core/u2u8_front.sv
rtl/core/u2u8_queue.sv
rtl/core/u2u8_back.sv
rtl/core/utf16_to_utf8_encoder_core.sv
rtl/core/u2u8_checker.sv
test/utf8_stream_monitor.sv
test/utf16_to_utf8_encoder_core_tb.sv
